[rtl/core/bht_pkg.sv]
package bht_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned BIDX_W      = 4;
  localparam int unsigned SIDX_W      = 2;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned BCNT_W      = 5;
  localparam int unsigned SCNT_W      = 3;

  // Search results are capped at this many hits.
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // Register reset values.
  localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 5'd16;
  localparam logic [SCNT_W-1:0] SLOTS_RST        = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED    = 3'd0,
    ST_FULL        = 3'd1,
    ST_DELETED     = 3'd2,
    ST_DELETE_MISS = 3'd3,
    ST_SEARCH_HIT  = 3'd4,
    ST_SEARCH_MISS = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUCKET_COUNT     = 1'b0,
    CFG_SLOTS_PER_BUCKET = 1'b1
  } cfg_idx_e;

endpackage

[rtl/core/bht_ram.sv]
module bht_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/bht_mod.sv]
module bht_mod import bht_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CFG_W-1:0] rem_o
);

  localparam int unsigned STEP_W = $clog2(KEY_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [KEY_W-1:0]  dvd_q, dvd_d;
  logic [CFG_W-1:0]  rem_q, rem_d;
  logic [CFG_W:0]    trial;

  // Restoring remainder, one dividend bit per cycle. The remainder stays
  // below the divisor, so the trial value is below twice the divisor.
  always_comb begin
    trial  = {rem_q, dvd_q[KEY_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = CFG_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[CFG_W-1:0];
      end
      dvd_d  = {dvd_q[KEY_W-2:0], 1'b0};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/bucketed_hash_table_top.sv]
// Bucketed hash table of 31-bit keys, BUCKETS buckets of SLOTS slots, with
// insert (forward probing to the last bucket in use, no wrap), delete in the
// home bucket only, and search over every slot in use with one result per
// hit (at most 64) or one miss result. One command is in work at a time.
// Insert and delete first compute the home bucket with a bit-serial
// remainder unit, then probe the table memory slot by slot (address, then
// registered read and compare), and emit the result through the output
// register. Search probes every slot in use from bucket zero in the same
// way. After reset a clearing pass writes all BUCKETS * SLOTS entries of
// the memory before the first command is taken; configuration writes are
// taken during it.
module bucketed_hash_table_top import bht_pkg::*; #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned SLOTS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     in_cmd_i,
  input  logic [KEY_W-1:0]     in_key_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  out_status_o,
  output logic [BIDX_W-1:0]    out_bucket_index_o,
  output logic [SIDX_W-1:0]    out_slot_index_o,
  output logic                 out_last_o
);

  localparam int unsigned DEPTH = BUCKETS * SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RAM_W = KEY_W + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  state_e              nxt_q, nxt_d;
  cmd_e                cmd_q, cmd_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [BCNT_W-1:0]   home_q, home_d;
  logic [BCNT_W-1:0]   b_q, b_d;
  logic [SCNT_W-1:0]   s_q, s_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                pend_q, pend_d;
  logic [BCNT_W-1:0]   pend_b_q, pend_b_d;
  logic [SCNT_W-1:0]   pend_s_q, pend_s_d;
  status_e             res_status_q, res_status_d;
  logic [BCNT_W-1:0]   res_b_q, res_b_d;
  logic [SCNT_W-1:0]   res_s_q, res_s_d;
  logic                res_last_q, res_last_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [BCNT_W-1:0]   bucket_count_q;
  logic [SCNT_W-1:0]   slots_q;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [BIDX_W-1:0]   out_b_q;
  logic [SIDX_W-1:0]   out_s_q;
  logic                out_last_q;
  logic                out_load;

  logic [BCNT_W-1:0]   nb;
  logic [SCNT_W-1:0]   ns;
  logic                div_start;
  logic                div_done;
  logic [CFG_W-1:0]    div_rem;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [RAM_W-1:0]    ram_wdata;
  logic [AW-1:0]       scan_addr;
  logic [RAM_W-1:0]    ram_rdata;
  logic                hit;
  logic                slot_end;
  logic                bucket_end;
  logic [CNT_W-1:0]    cnt_inc;
  logic                search_done;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
      slots_q        <= SLOTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BUCKET_COUNT:     bucket_count_q <= cfg_wdata_i[BCNT_W-1:0];
        CFG_SLOTS_PER_BUCKET: slots_q        <= cfg_wdata_i[SCNT_W-1:0];
        default:              ;
      endcase
    end
  end

  // Counts in use, saturated to 1..BUCKETS and 1..SLOTS.
  always_comb begin
    if (bucket_count_q == '0) begin
      nb = BCNT_W'(1);
    end else if (32'(bucket_count_q) > BUCKETS) begin
      nb = BCNT_W'(BUCKETS);
    end else begin
      nb = bucket_count_q;
    end
    if (slots_q == '0) begin
      ns = SCNT_W'(1);
    end else if (32'(slots_q) > SLOTS) begin
      ns = SCNT_W'(SLOTS);
    end else begin
      ns = slots_q;
    end
  end

  // Home bucket unit.
  bht_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (key_d),
    .divisor_i  (nb),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Table memory: valid bit over key.
  assign scan_addr = AW'(32'(b_q) * SLOTS + 32'(s_q));

  bht_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_addr),
    .rdata_o (ram_rdata)
  );

  assign hit        = ram_rdata[KEY_W] && (ram_rdata[KEY_W-1:0] == key_q);
  assign slot_end   = (s_q + SCNT_W'(1)) == ns;
  assign bucket_end = (b_q + BCNT_W'(1)) == nb;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign search_done = (cnt_inc == CNT_W'(MAX_RESULTS)) || (slot_end && bucket_end);
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Command sequencer.
  always_comb begin
    state_d      = state_q;
    nxt_d        = nxt_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    home_d       = home_q;
    b_d          = b_q;
    s_d          = s_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_b_d     = pend_b_q;
    pend_s_d     = pend_s_q;
    res_status_d = res_status_q;
    res_b_d      = res_b_q;
    res_s_d      = res_s_q;
    res_last_d   = res_last_q;
    clr_d        = clr_q;
    div_start    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = scan_addr;
    ram_wdata    = {1'b1, key_q};

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_e'(in_cmd_i);
          key_d  = in_key_i;
          pend_d = 1'b0;
          cnt_d  = '0;
          b_d    = '0;
          s_d    = '0;
          unique case (cmd_e'(in_cmd_i))
            CMD_INSERT, CMD_DELETE: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
            CMD_SEARCH: state_d = S_READ;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          home_d  = div_rem;
          b_d     = div_rem;
          s_d     = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // Step to the next slot, and for insert and search the next bucket.
        if (!slot_end) begin
          s_d = s_q + SCNT_W'(1);
        end else begin
          s_d = '0;
          b_d = b_q + BCNT_W'(1);
        end
        state_d = S_READ;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (!ram_rdata[KEY_W]) begin
              ram_we       = 1'b1;
              ram_wdata    = {1'b1, key_q};
              res_status_d = ST_INSERTED;
              res_b_d      = b_q;
              res_s_d      = s_q;
              res_last_d   = 1'b1;
              nxt_d        = S_IDLE;
              state_d      = S_EMIT;
            end else if (slot_end && bucket_end) begin
              res_status_d = ST_FULL;
              res_b_d      = home_q;
              res_s_d      = '0;
              res_last_d   = 1'b1;
              nxt_d        = S_IDLE;
              state_d      = S_EMIT;
            end
          end
          CMD_DELETE: begin
            b_d = b_q;
            if (hit) begin
              ram_we       = 1'b1;
              ram_wdata    = {1'b0, key_q};
              res_status_d = ST_DELETED;
              res_b_d      = home_q;
              res_s_d      = s_q;
              res_last_d   = 1'b1;
              nxt_d        = S_IDLE;
              state_d      = S_EMIT;
            end else if (slot_end) begin
              res_status_d = ST_DELETE_MISS;
              res_b_d      = home_q;
              res_s_d      = '0;
              res_last_d   = 1'b1;
              nxt_d        = S_IDLE;
              state_d      = S_EMIT;
            end
          end
          default: begin
            // Search keeps one hit pending so that the final one gets last.
            if (hit) begin
              cnt_d    = cnt_inc;
              pend_d   = 1'b1;
              pend_b_d = b_q;
              pend_s_d = s_q;
              if (pend_q) begin
                res_status_d = ST_SEARCH_HIT;
                res_b_d      = pend_b_q;
                res_s_d      = pend_s_q;
                res_last_d   = 1'b0;
                nxt_d        = search_done ? S_FLUSH : S_READ;
                state_d      = S_EMIT;
              end else if (search_done) begin
                state_d = S_FLUSH;
              end
            end else if (slot_end && bucket_end) begin
              state_d = S_FLUSH;
            end
          end
        endcase
      end
      S_FLUSH: begin
        res_status_d = pend_q ? ST_SEARCH_HIT : ST_SEARCH_MISS;
        res_b_d      = pend_q ? pend_b_q : '0;
        res_s_d      = pend_q ? pend_s_q : '0;
        res_last_d   = 1'b1;
        nxt_d        = S_IDLE;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = nxt_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: a result waits here while the next one is worked out.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      nxt_q       <= S_IDLE;
      clr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_q       <= nxt_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    home_q       <= home_d;
    b_q          <= b_d;
    s_q          <= s_d;
    pend_b_q     <= pend_b_d;
    pend_s_q     <= pend_s_d;
    res_status_q <= res_status_d;
    res_b_q      <= res_b_d;
    res_s_q      <= res_s_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_b_q      <= res_b_q[BIDX_W-1:0];
      out_s_q      <= res_s_q[SIDX_W-1:0];
      out_last_q   <= res_last_q;
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_bucket_index_o = out_b_q;
  assign out_slot_index_o   = out_s_q;
  assign out_last_o         = out_last_q;

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("home bucket ready outside the modulo wait");

  // The table is written only by the clearing pass or a slot check.
  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
    else $error("table write outside clear or check");

  // A new result appears only after the emit step.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result shown without an emit step");

  // The hit count never passes the result cap.
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_RESULTS)
    else $error("search hit count above cap");

endmodule

[tb/bucketed_hash_table_top_test.sv]
module bucketed_hash_table_top_test;
  import bht_pkg::*;

  localparam int unsigned NUM_BUCKETS = 16;
  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned TABLE_DEPTH = NUM_BUCKETS * NUM_SLOTS;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam int unsigned IDLE_PERCENT = 22;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BIDX_W-1:0]   bucket;
    logic [SIDX_W-1:0]   slot;
    logic                last;
  } reply_t;

  // Mirror of the table contents and the register file, with the queue of
  // replies that the block still owes.
  class hash_table_scoreboard;
    bit                slot_used[TABLE_DEPTH];
    logic [KEY_W-1:0]  slot_key[TABLE_DEPTH];
    logic [BCNT_W-1:0] bucket_count;
    logic [SCNT_W-1:0] slots_per_bucket;
    reply_t            pending_replies[$];
    int unsigned       mismatches;

    function new();
      bucket_count     = BUCKET_COUNT_RST;
      slots_per_bucket = SLOTS_RST;
      mismatches       = 0;
    endfunction

    function void write_register(cfg_idx_e idx, logic [CFG_W-1:0] data);
      if (idx == CFG_BUCKET_COUNT) begin
        bucket_count = data[BCNT_W-1:0];
      end else begin
        slots_per_bucket = data[SCNT_W-1:0];
      end
    endfunction

    function void push_reply(status_e status, int unsigned bucket, int unsigned slot,
                             logic last);
      reply_t r;
      r.status = status;
      r.bucket = BIDX_W'(bucket);
      r.slot   = SIDX_W'(slot);
      r.last   = last;
      pending_replies.push_back(r);
    endfunction

    // Work out the replies to one accepted command and update the mirror.
    function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
      int unsigned nb, ns, home, idx, hits, b, s;
      bit done;
      reply_t r;
      nb = (bucket_count == '0) ? 1 :
           (32'(bucket_count) > NUM_BUCKETS) ? NUM_BUCKETS : 32'(bucket_count);
      ns = (slots_per_bucket == '0) ? 1 :
           (32'(slots_per_bucket) > NUM_SLOTS) ? NUM_SLOTS : 32'(slots_per_bucket);
      home = 32'(key) % nb;
      done = 1'b0;
      hits = 0;
      case (cmd)
        CMD_INSERT: begin
          // Probe forward from the home bucket; there is no wrap to bucket zero.
          for (b = home; b < nb && !done; b++) begin
            for (s = 0; s < ns && !done; s++) begin
              idx = b * NUM_SLOTS + s;
              if (!slot_used[idx]) begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = key;
                push_reply(ST_INSERTED, b, s, 1'b1);
                done = 1'b1;
              end
            end
          end
          if (!done) push_reply(ST_FULL, home, 0, 1'b1);
        end
        CMD_DELETE: begin
          // Only the home bucket is searched for the key to remove.
          for (s = 0; s < ns && !done; s++) begin
            idx = home * NUM_SLOTS + s;
            if (slot_used[idx] && slot_key[idx] == key) begin
              slot_used[idx] = 1'b0;
              push_reply(ST_DELETED, home, s, 1'b1);
              done = 1'b1;
            end
          end
          if (!done) push_reply(ST_DELETE_MISS, home, 0, 1'b1);
        end
        CMD_SEARCH: begin
          for (b = 0; b < nb; b++) begin
            for (s = 0; s < ns; s++) begin
              idx = b * NUM_SLOTS + s;
              if (slot_used[idx] && slot_key[idx] == key && hits < MAX_RESULTS) begin
                push_reply(ST_SEARCH_HIT, b, s, 1'b0);
                hits++;
              end
            end
          end
          if (hits == 0) begin
            push_reply(ST_SEARCH_MISS, 0, 0, 1'b1);
          end else begin
            r = pending_replies.pop_back();
            r.last = 1'b1;
            pending_replies.push_back(r);
          end
        end
        default: begin
          // The unused code changes nothing and returns nothing.
        end
      endcase
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual status %0d bucket %0d",
                 $time, got.status, got.bucket);
        $display("%0t: unexpected result: actual slot %0d last %0d",
                 $time, got.slot, got.last);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", 4'(want.status), 4'(got.status));
      compare_field("bucket_index", want.bucket, got.bucket);
      compare_field("slot_index", 4'(want.slot), 4'(got.slot));
      compare_field("last", 4'(want.last), 4'(got.last));
    endfunction

    function int unsigned outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     in_cmd_i = '0;
  logic [KEY_W-1:0]     in_key_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  out_status_o;
  logic [BIDX_W-1:0]    out_bucket_index_o;
  logic [SIDX_W-1:0]    out_slot_index_o;
  logic                 out_last_o;

  bit quiet_mode = 1'b0;
  bit hold_request = 1'b0;
  int unsigned idle_run = 0;
  hash_table_scoreboard table_sb = new();

  always #2 clk_i = ~clk_i;

  bucketed_hash_table_top #(
    .BUCKETS(NUM_BUCKETS),
    .SLOTS  (NUM_SLOTS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_cmd_i          (in_cmd_i),
    .in_key_i          (in_key_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_status_o      (out_status_o),
    .out_bucket_index_o(out_bucket_index_o),
    .out_slot_index_o  (out_slot_index_o),
    .out_last_o        (out_last_o)
  );

  // Note every command transfer and check every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) table_sb.note_command(in_cmd_i, in_key_i);
      if (out_valid_o && !out_stall_i) begin
        table_sb.check_reply({out_status_o, out_bucket_index_o, out_slot_index_o, out_last_o});
      end
    end
  end

  // Give up when no transfer of either kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_run <= 0;
      end else if (idle_run + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // Result side: random stalls, none in a quiet stretch, and one long hold-off on request.
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= !quiet_mode && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned n;
    n = 0;
    if (!quiet_mode) begin
      while ($urandom_range(99) < IDLE_PERCENT) n++;
    end
    return n;
  endfunction

  // Offer one command, after a random gap, and hold it until the transfer.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
    int unsigned gap;
    gap = idle_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_cmd_i   <= cmd;
    in_key_i   <= key;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (table_sb.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic program_register(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    table_sb.write_register(idx, data);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic reconfigure(logic [CFG_W-1:0] buckets, logic [CFG_W-1:0] slots);
    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    program_register(CFG_BUCKET_COUNT, buckets);
    program_register(CFG_SLOTS_PER_BUCKET, slots);
  endtask

  // Random commands: mostly keys from a small set so that inserts, deletes and
  // searches meet each other, with some keys spread over the whole range.
  task automatic run_random(int unsigned count);
    logic [KEY_W-1:0] key_set[8];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int unsigned pick;
    foreach (key_set[i]) begin
      key_set[i] = (i < 4) ? KEY_W'($urandom_range(40)) : KEY_W'($urandom);
    end
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 40) cmd = CMD_INSERT;
      else if (pick < 68) cmd = CMD_DELETE;
      else if (pick < 95) cmd = CMD_SEARCH;
      else cmd = CMD_UNUSED;
      key = ($urandom_range(9) < 8) ? key_set[$urandom_range(7)] : KEY_W'($urandom);
      send_command(cmd, key);
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed commands on the full default table.
    reconfigure(5'd16, 5'd4);
    send_command(CMD_SEARCH, 31'd0);
    send_command(CMD_INSERT, 31'd0);
    repeat (4) send_command(CMD_INSERT, KEY_MAX);
    // The last bucket is now full and probing does not wrap.
    send_command(CMD_INSERT, KEY_MAX);
    send_command(CMD_SEARCH, KEY_MAX);
    send_command(CMD_DELETE, KEY_MAX);
    send_command(CMD_DELETE, 31'd5);
    send_command(CMD_DELETE, 31'd16);
    send_command(CMD_UNUSED, KEY_MAX);
    send_command(CMD_SEARCH, 31'd0);
    send_command(CMD_DELETE, 31'd0);
    // Five copies of one key spill from its home bucket into the next one.
    repeat (5) send_command(CMD_INSERT, 31'd14);
    send_command(CMD_SEARCH, 31'd14);

    // Smallest table, then zero registers which act as one.
    reconfigure(5'd1, 5'd1);
    send_command(CMD_INSERT, 31'd7);
    send_command(CMD_INSERT, 31'd8);
    run_random(38);
    reconfigure(5'd0, 5'd0);
    run_random(40);

    // Out-of-range values saturate; the result side holds off for a while.
    reconfigure(5'd31, 5'b11101);
    hold_request = 1'b1;
    run_random(70);

    // Sender pauses midway until everything owed has come back.
    reconfigure(5'd3, 5'd2);
    run_random(35);
    stop_sending();
    wait_drained();
    run_random(35);

    // Full table, first without any idling on either side.
    reconfigure(5'd16, 5'd4);
    quiet_mode = 1'b1;
    run_random(40);
    quiet_mode = 1'b0;
    run_random(40);

    reconfigure(5'd5, 5'd3);
    run_random(70);
    reconfigure(5'd2, 5'd7);
    run_random(70);

    stop_sending();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (table_sb.mismatches == 0 && table_sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
